@@ design/tccw_pkg.sv @@
package tccw_pkg;

  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STOP_DEF = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_FG_IDX = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BG_IDX = CFG_IDX_W'(1);

  localparam logic [CFG_DATA_W-1:0] FG_RESET = CFG_DATA_W'(7);
  localparam logic [CFG_DATA_W-1:0] BG_RESET = CFG_DATA_W'(0);

  localparam logic REQ_PUT   = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [15:0] BLANK_CELL = 16'h0020;
  localparam logic [15:0] ERASE_CELL = 16'h0720;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_PUT,
    ST_SCROLL,
    ST_CLEAR,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic latch;
    logic home;
    logic load_glyph;
    logic load_tab;
    logic put_step;
    logic nl_step;
    logic bs_step;
    logic sweep_start;
    logic sweep_run;
    logic sweep_blank;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_nl;
    logic is_tab;
    logic is_bs;
    logic at_bottom;
    logic wrap_next;
    logic cnt_last;
    logic cnt_zero;
    logic sweep_done;
    logic out_free;
  } dp_status_t;

endpackage

@@ design/tccw_ctrl.sv @@
module tccw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  tccw_pkg::dp_status_t sts,
  output tccw_pkg::ctrl_cmd_t  cmd
);
  import tccw_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        cmd.sweep_run   = 1'b1;
        cmd.sweep_blank = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts.is_clear) begin
          cmd.home        = 1'b1;
          cmd.sweep_start = 1'b1;
          state_nxt       = ST_CLEAR;
        end else if (sts.is_nl) begin
          cmd.nl_step = 1'b1;
          if (sts.at_bottom) begin
            cmd.sweep_start = 1'b1;
            state_nxt       = ST_SCROLL;
          end else begin
            state_nxt = ST_DONE;
          end
        end else if (sts.is_bs) begin
          cmd.bs_step = 1'b1;
          state_nxt   = ST_DONE;
        end else if (sts.is_tab) begin
          cmd.load_tab = 1'b1;
          state_nxt    = ST_PUT;
        end else begin
          cmd.load_glyph = 1'b1;
          state_nxt      = ST_PUT;
        end
      end
      ST_PUT: begin
        cmd.put_step = 1'b1;
        if (sts.wrap_next && sts.at_bottom) begin
          cmd.sweep_start = 1'b1;
          state_nxt       = ST_SCROLL;
        end else if (sts.cnt_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCROLL: begin
        cmd.sweep_run = 1'b1;
        if (sts.sweep_done) begin
          // tab spaces may remain after a wrap
          state_nxt = sts.cnt_zero ? ST_DONE : ST_PUT;
        end
      end
      ST_CLEAR: begin
        cmd.sweep_run   = 1'b1;
        cmd.sweep_blank = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

endmodule

@@ design/tccw_datapath.sv @@
module tccw_datapath #(
  parameter int COLUMNS  = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS     = tccw_pkg::ROWS_DEF,
  parameter int TAB_STOP = tccw_pkg::TAB_STOP_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tccw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_tuser,
  input  logic [7:0]                      in_tdata,
  input  logic                            out_tready,
  output logic                            out_tvalid,
  output logic [23:0]                     out_tdata,
  input  tccw_pkg::ctrl_cmd_t             cmd,
  output tccw_pkg::dp_status_t            sts
);
  import tccw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int MOVE  = COLUMNS * (ROWS - 1);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = $clog2(CELLS + 1);
  localparam int PH_W  = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int CNT_W = $clog2(TAB_STOP + 1);

  localparam logic [CW-1:0]    COL_LAST = CW'(COLUMNS - 1);
  localparam logic [RW-1:0]    ROW_LAST = RW'(ROWS - 1);
  localparam logic [AW-1:0]    BOT_POS  = AW'(MOVE);
  localparam logic [AW-1:0]    COL_STEP = AW'(COLUMNS);
  localparam logic [PH_W-1:0]  PH_MAX   = PH_W'(TAB_STOP - 1);
  localparam logic [PH_W-1:0]  PH_WRAP  = PH_W'((COLUMNS - 1) % TAB_STOP);
  localparam logic [CNT_W-1:0] TAB_N    = CNT_W'(TAB_STOP);
  localparam logic [SW-1:0]    SW_END   = SW'(CELLS);
  localparam logic [SW-1:0]    SW_MOVE  = SW'(MOVE);
  localparam logic [SW-1:0]    SW_COLS  = SW'(COLUMNS);

  // colours
  logic [CFG_DATA_W-1:0] fg_r, bg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= FG_RESET;
      bg_r <= BG_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_FG_IDX) fg_r <= cfg_data;
      if (cfg_index == CFG_BG_IDX) bg_r <= cfg_data;
    end
  end

  // latched item
  logic       req_r;
  logic [7:0] ch_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= in_tuser;
      ch_r  <= in_tdata;
    end
  end

  // cursor; ph_r tracks col mod TAB_STOP
  logic [CW-1:0]    col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [PH_W-1:0]  ph_r, ph_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             scroll_r, scroll_nxt;
  logic             at_home, at_bottom, wrap_next, is_tab;
  logic [7:0]       put_ch;

  assign at_home   = (pos_r == '0);
  assign at_bottom = (row_r == ROW_LAST);
  assign wrap_next = (col_r == COL_LAST);
  assign is_tab    = (ch_r == CH_TAB);
  assign put_ch    = is_tab ? CH_SPACE : ch_r;

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    pos_nxt    = pos_r;
    ph_nxt     = ph_r;
    cnt_nxt    = cnt_r;
    scroll_nxt = scroll_r;
    if (cmd.latch) begin
      scroll_nxt = 1'b0;
      cnt_nxt    = '0;
    end
    if (cmd.home) begin
      col_nxt = '0;
      row_nxt = '0;
      pos_nxt = '0;
      ph_nxt  = '0;
    end
    if (cmd.load_glyph) begin
      cnt_nxt = CNT_W'(1);
    end
    if (cmd.load_tab) begin
      cnt_nxt = TAB_N - CNT_W'(ph_r);
    end
    if (cmd.put_step) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (wrap_next) begin
        col_nxt = '0;
        ph_nxt  = '0;
        if (at_bottom) begin
          pos_nxt    = BOT_POS;
          scroll_nxt = 1'b1;
        end else begin
          row_nxt = row_r + RW'(1);
          pos_nxt = pos_r + AW'(1);
        end
      end else begin
        col_nxt = col_r + CW'(1);
        pos_nxt = pos_r + AW'(1);
        ph_nxt  = (ph_r == PH_MAX) ? '0 : ph_r + PH_W'(1);
      end
    end
    if (cmd.nl_step) begin
      col_nxt = '0;
      ph_nxt  = '0;
      if (at_bottom) begin
        pos_nxt    = BOT_POS;
        scroll_nxt = 1'b1;
      end else begin
        row_nxt = row_r + RW'(1);
        pos_nxt = pos_r + COL_STEP - AW'(col_r);
      end
    end
    if (cmd.bs_step && !at_home) begin
      pos_nxt = pos_r - AW'(1);
      if (col_r == '0) begin
        row_nxt = row_r - RW'(1);
        col_nxt = COL_LAST;
        ph_nxt  = PH_WRAP;
      end else begin
        col_nxt = col_r - CW'(1);
        ph_nxt  = (ph_r == '0) ? PH_MAX : ph_r - PH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      pos_r    <= '0;
      ph_r     <= '0;
      cnt_r    <= '0;
      scroll_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      pos_r    <= pos_nxt;
      ph_r     <= ph_nxt;
      cnt_r    <= cnt_nxt;
      scroll_r <= scroll_nxt;
    end
  end

  // sweep: one cell a cycle; scroll reads cell+COLUMNS and writes it to cell in the next cycle
  logic [SW-1:0] sw_r, sw_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [AW-1:0] pend_addr_r;
  logic          pend_blank_r;
  logic          sw_busy;
  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_data_r;

  assign sw_busy    = cmd.sweep_run && (sw_r != SW_END);
  assign pend_v_nxt = sw_busy;
  assign rd_addr    = (sw_r < SW_MOVE) ? AW'(sw_r + SW_COLS) : '0;

  always_comb begin
    sw_nxt = sw_r;
    if (cmd.sweep_start) begin
      sw_nxt = '0;
    end else if (sw_busy) begin
      sw_nxt = sw_r + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r     <= '0;
      pend_v_r <= 1'b0;
    end else begin
      sw_r     <= sw_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sw_busy) begin
      pend_addr_r  <= AW'(sw_r);
      pend_blank_r <= cmd.sweep_blank || (sw_r >= SW_MOVE);
    end
  end

  // cell store
  logic [15:0]   mem [CELLS];
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;

  always_comb begin
    we    = 1'b0;
    waddr = pos_r;
    wdata = BLANK_CELL;
    if (pend_v_r) begin
      we    = 1'b1;
      waddr = pend_addr_r;
      wdata = pend_blank_r ? BLANK_CELL : rd_data_r;
    end else if (cmd.put_step) begin
      we    = 1'b1;
      waddr = pos_r;
      wdata = {bg_r, fg_r, put_ch};
    end else if (cmd.bs_step && !at_home) begin
      we    = 1'b1;
      waddr = pos_r - AW'(1);
      wdata = ERASE_CELL;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  // result register
  logic        out_valid_r;
  logic [10:0] out_pos_r;
  logic [6:0]  out_col_r;
  logic [4:0]  out_row_r;
  logic        out_scr_r;
  logic        out_free;

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_pos_r <= 11'(pos_r);
      out_col_r <= 7'(col_r);
      out_row_r <= 5'(row_r);
      out_scr_r <= scroll_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_scr_r, out_row_r, out_col_r, out_pos_r};

  always_comb begin
    sts            = '0;
    sts.is_clear   = (req_r == REQ_CLEAR);
    sts.is_nl      = (ch_r == CH_NL);
    sts.is_tab     = is_tab;
    sts.is_bs      = (ch_r == CH_BS);
    sts.at_bottom  = at_bottom;
    sts.wrap_next  = wrap_next;
    sts.cnt_last   = (cnt_r == CNT_W'(1));
    sts.cnt_zero   = (cnt_r == '0);
    sts.sweep_done = (sw_r == SW_END);
    sts.out_free   = out_free;
  end

endmodule

@@ design/text_console_cell_writer_unit.sv @@
// Text console cell writer: keeps a ROWS x COLUMNS store of 16-bit cells
// (attribute byte over character byte) and a cursor.
// Input channel in_*: one item is a put-character or clear-screen request.
// Output channel out_*: exactly one result item per input item, giving the
// cursor position after the item and whether the screen scrolled.
// cfg_*: writes the foreground (index 0) and background (index 1) colours;
// always ready, other indexes are dropped.
// After reset the store is blanked one cell per cycle, with in_tready low
// during that pass.
// One item at a time: the next item is accepted only after the result of the
// last one is loaded into the output register. A tab writes spaces up to the
// next tab stop.
// A scroll or a clear sweeps the whole store through its single write
// port.
// The result sits in an output register; a new item is accepted while it
// waits. If the receiver stalls, the following item completes its work and
// holds until the register is free.
module text_console_cell_writer_unit #(
  parameter int COLUMNS  = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS     = tccw_pkg::ROWS_DEF,
  parameter int TAB_STOP = tccw_pkg::TAB_STOP_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tccw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] char_code
  input  logic                            in_tuser,   // [0] req_type
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata   // [10:0] cursor_pos, [17:11] cursor_col,
                                                      // [22:18] cursor_row, [23] scrolled
);
  import tccw_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  assign cfg_ready = 1'b1;

  tccw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tccw_datapath #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item accepted while one is in work");

  a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put_step |-> !cmd.sweep_run)
    else $error("cell write collides with sweep");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result register overwritten before taken");

  a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sweep_run |-> !in_tready)
    else $error("input ready during store sweep");

endmodule

@@ tb/tb_text_console_cell_writer_unit.sv @@
module tb_text_console_cell_writer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tccw_pkg::*;

  localparam int NUM_COLS    = COLUMNS_DEF;
  localparam int NUM_ROWS    = ROWS_DEF;
  localparam int TAB_SPAN    = TAB_STOP_DEF;
  localparam int NUM_CELLS   = NUM_COLS * NUM_ROWS;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int TAIL_CYCLES = 40;

  // indexes past the register list, dropped by the block
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

  localparam logic [7:0] CTRL_CHARS [3] = '{CH_NL, CH_TAB, CH_BS};

  // matches out_tdata: [10:0] pos, [17:11] col, [22:18] row, [23] scrolled
  typedef struct packed {
    logic       scrolled;
    logic [4:0] row;
    logic [6:0] col;
    logic [10:0] pos;
  } cursor_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;

  text_console_cell_writer_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // console state as the block should hold it
  logic [15:0]    screen_model [NUM_CELLS];
  int             cur_col = 0;
  int             cur_row = 0;
  logic [3:0]     fg_model = FG_RESET;
  logic [3:0]     bg_model = BG_RESET;
  logic           did_scroll = 1'b0;

  cursor_report_t expected_cursor [$];
  int             items_sent = 0;
  int             mismatch_count = 0;
  int             tx_idle_pct = 0;
  int             rx_idle_pct = 0;
  int             cycle_count = 0;

  function automatic void blank_screen();
    foreach (screen_model[i]) screen_model[i] = BLANK_CELL;
  endfunction

  function automatic void advance_line();
    cur_col = 0;
    cur_row++;
    if (cur_row > NUM_ROWS - 1) begin
      for (int i = 0; i < NUM_COLS * (NUM_ROWS - 1); i++)
        screen_model[i] = screen_model[i + NUM_COLS];
      for (int i = NUM_COLS * (NUM_ROWS - 1); i < NUM_CELLS; i++)
        screen_model[i] = BLANK_CELL;
      cur_row    = NUM_ROWS - 1;
      did_scroll = 1'b1;
    end
  endfunction

  function automatic void put_cell(logic [7:0] ch);
    screen_model[cur_row * NUM_COLS + cur_col] = {bg_model, fg_model, ch};
    cur_col++;
    if (cur_col >= NUM_COLS) advance_line();
  endfunction

  function automatic cursor_report_t apply_request(logic req, logic [7:0] ch);
    cursor_report_t r;
    did_scroll = 1'b0;
    if (req == REQ_CLEAR) begin
      blank_screen();
      cur_col = 0;
      cur_row = 0;
    end else if (ch == CH_NL) begin
      advance_line();
    end else if (ch == CH_TAB) begin
      repeat (TAB_SPAN - cur_col % TAB_SPAN) put_cell(CH_SPACE);
    end else if (ch == CH_BS) begin
      if (cur_col != 0 || cur_row != 0) begin
        if (cur_col == 0) begin
          cur_row--;
          cur_col = NUM_COLS - 1;
        end else begin
          cur_col--;
        end
        screen_model[cur_row * NUM_COLS + cur_col] = ERASE_CELL;
      end
    end else begin
      put_cell(ch);
    end
    r.pos      = 11'(cur_row * NUM_COLS + cur_col);
    r.col      = 7'(cur_col);
    r.row      = 5'(cur_row);
    r.scrolled = did_scroll;
    return r;
  endfunction

  function automatic logic [7:0] any_glyph();
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, 255));
    while (ch == CH_NL || ch == CH_TAB || ch == CH_BS);
    return ch;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH @%0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // valid stays high after an item unless a gap or a drain follows
  task automatic send_item(input logic req, input logic [7:0] ch);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk);
      while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= ch;
    do @(posedge clk);
    while (!in_tready);
    expected_cursor.push_back(apply_request(req, ch));
    items_sent++;
  endtask

  task automatic drain_results();
    if (expected_cursor.size() != 0) begin
      in_tvalid <= 1'b0;
      while (expected_cursor.size() != 0) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == CFG_FG_IDX) fg_model = value;
    else if (idx == CFG_BG_IDX) bg_model = value;
  endtask

  // only while nothing is in flight
  task automatic set_colours(input logic [3:0] fg, input logic [3:0] bg);
    write_reg(CFG_FG_IDX, fg);
    write_reg(CFG_BG_IDX, bg);
    write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic test_colour_registers();
    set_colours(4'hF, 4'hF);
  endtask

  task automatic test_directed_edits();
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    send_item(REQ_PUT, CH_BS);          // backspace at home
    send_item(REQ_PUT, 8'h00);
    send_item(REQ_PUT, 8'hFF);
    send_item(REQ_PUT, CH_TAB);         // two spaces to the stop
    send_item(REQ_PUT, CH_TAB);         // full stop width
    send_item(REQ_PUT, CH_NL);
    drain_results();
    send_item(REQ_PUT, CH_BS);          // wraps to end of previous row
    send_item(REQ_PUT, 8'h41);          // last column, wraps forward
    send_item(REQ_PUT, CH_BS);
    send_item(REQ_PUT, CH_TAB);         // one space, wraps forward
    send_item(REQ_PUT, CH_SPACE);
    send_item(REQ_PUT, 8'h7F);
    send_item(REQ_PUT, 8'h80);
    send_item(REQ_CLEAR, 8'hFF);
    send_item(REQ_PUT, CH_NL);
    send_item(REQ_CLEAR, CH_NL);        // clear wins over the char
    send_item(REQ_PUT, CH_BS);
    drain_results();
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count,
                                     input logic [3:0] fg, input logic [3:0] bg);
    int goal;
    int pick;
    int len;
    int target;
    set_colours(fg, bg);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    goal = items_sent + count;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // text line, mostly short so the cursor reaches the bottom and scrolls
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 20);
        repeat (len) send_item(REQ_PUT, ($urandom_range(0, 7) == 0) ? CH_TAB : any_glyph());
        send_item(REQ_PUT, CH_NL);
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 6)) send_item(REQ_PUT, any_glyph());
        repeat ($urandom_range(1, 12)) send_item(REQ_PUT, CH_BS);
      end else if (pick < 80) begin
        // walk up near the line end, then send a tab, which wraps, or a glyph
        target = $urandom_range(NUM_COLS - TAB_SPAN, NUM_COLS - 1);
        while (cur_col < target) send_item(REQ_PUT, any_glyph());
        send_item(REQ_PUT, ($urandom_range(0, 1) == 0) ? CH_TAB : any_glyph());
      end else if (pick < 82) begin
        send_item(REQ_CLEAR, 8'($urandom_range(0, 255)));
      end else if (pick < 98) begin
        send_item(($urandom_range(0, 19) == 0) ? REQ_CLEAR : REQ_PUT,
                  ($urandom_range(0, 3) == 0) ? CTRL_CHARS[$urandom_range(0, 2)]
                                              : 8'($urandom_range(0, 255)));
      end else begin
        drain_results();
      end
    end
    drain_results();
  endtask

  always @(posedge clk) begin
    cursor_report_t got;
    cursor_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_cursor.size() == 0) begin
        report_mismatch("unexpected result, pos", int'(got.pos), 0);
      end else begin
        want = expected_cursor.pop_front();
        if (got.pos != want.pos)
          report_mismatch("cursor_pos", int'(got.pos), int'(want.pos));
        if (got.col != want.col)
          report_mismatch("cursor_col", int'(got.col), int'(want.col));
        if (got.row != want.row)
          report_mismatch("cursor_row", int'(got.row), int'(want.row));
        if (got.scrolled != want.scrolled)
          report_mismatch("scrolled", int'(got.scrolled), int'(want.scrolled));
      end
    end
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    blank_screen();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_colour_registers();
    test_directed_edits();
    test_random_traffic(26, 88, 430, 4'h0, 4'h0);
    test_random_traffic(88, 26, 430, 4'($urandom), 4'($urandom));
    test_random_traffic(0, 0, 430, FG_RESET, BG_RESET);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_cursor.size() != 0)
      report_mismatch("results still outstanding", 0, expected_cursor.size());
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/tccw_pkg.sv
design/tccw_ctrl.sv
design/tccw_datapath.sv
design/text_console_cell_writer_unit.sv
tb/tb_text_console_cell_writer_unit.sv
